FILE: src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by deq_cell, double_ended_queue and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Default sizes; the top level takes these as parameter defaults.
    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_WORD_WIDTH = 32;

    // Fixed field widths of the item and result ports.
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    // Intermediate width for resizing between the port and the stored word.
    localparam int WIDE_W   = 64;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_ROT_LEFT   = 3'd4,
        OP_ROT_RIGHT  = 3'd5
    } deq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // One-hot command broadcast to every cell; already qualified by the
    // full, empty and two-element checks.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic rot_left;
        logic rot_right;
    } deq_ctrl_t;

endpackage : deq_pkg

`default_nettype wire

FILE: src/deq_cell.sv
// One storage cell of the queue row: a word and its valid bit.
// Depends on deq_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
    parameter int WORD_WIDTH = deq_pkg::DEQ_WORD_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire deq_pkg::deq_ctrl_t    ctrl,
    input  wire logic                  left_valid,
    input  wire logic [WORD_WIDTH-1:0] left_data,
    input  wire logic                  right_valid,
    input  wire logic [WORD_WIDTH-1:0] right_data,
    input  wire logic [WORD_WIDTH-1:0] bcast_data,
    output logic                       valid,
    output logic [WORD_WIDTH-1:0]      data,
    output logic [WORD_WIDTH-1:0]      tap
);
    import deq_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [WORD_WIDTH-1:0] data_reg;
    logic [WORD_WIDTH-1:0] data_next;
    logic                  is_last;
    logic                  first_free;

    assign is_last    = valid_reg & ~right_valid;
    assign first_free = ~valid_reg & left_valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.push_front)
        begin
            // whole row moves one place back
            data_next  = left_data;
            valid_next = valid_reg | left_valid;
        end
        else if (ctrl.push_back)
        begin
            if (first_free)
            begin
                data_next  = bcast_data;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.pop_back)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
        end
        else if (ctrl.rot_left)
        begin
            if (valid_reg)
            begin
                data_next = is_last ? bcast_data : right_data;
            end
        end
        else if (ctrl.rot_right)
        begin
            if (valid_reg)
            begin
                data_next = left_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    // only the back element drives the shared back-word bus
    assign tap   = is_last ? data_reg : '0;

endmodule : deq_cell

`default_nettype wire

FILE: src/double_ended_queue.sv
// Top level of the bounded double-ended queue: cell row, command decode,
// result buffer. Depends on deq_pkg and deq_cell.
// The queue is a row of DEPTH cells with the front element always in cell 0
// and the elements packed towards it; a valid bit per cell marks occupancy.
// Every operation (push or pop at either end, rotate left or right) updates
// the row together: each cell loads from its left or right neighbour, from
// the push word, or from the front/back element broadcast along the row,
// so one item is taken per cycle while item_stall is low. The back element
// is found by an OR over the cell outputs, which sets the longest path as
// DEPTH grows. Each item gives one result (popped word, status, occupancy
// after the operation) through a two-entry output buffer, so an item is
// still taken while one result waits stalled; item_stall rises only once
// both entries hold results. Pop on an empty queue returns zero with
// status empty; push on a full queue is dropped with status full; rotate
// with fewer than two elements and unused func codes do nothing. Reset
// clears the valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEQ_WORD_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [deq_pkg::FUNC_W-1:0]   func,
    input  wire logic [deq_pkg::VALUE_W-1:0]  push_value,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [deq_pkg::VALUE_W-1:0]       pop_value,
    output logic [deq_pkg::STATUS_W-1:0]      status,
    output logic [$clog2(DEPTH+1)-1:0]        occupancy
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // cell row wiring
    deq_ctrl_t             ctrl;
    logic [DEPTH-1:0]      valid_vec;
    logic [WORD_WIDTH-1:0] cell_data [DEPTH];
    logic [WORD_WIDTH-1:0] cell_tap  [DEPTH];
    logic [WORD_WIDTH-1:0] head_in;
    logic [WORD_WIDTH-1:0] bcast;
    logic [WORD_WIDTH-1:0] front_word;
    logic [WORD_WIDTH-1:0] back_word;
    logic [WORD_WIDTH-1:0] word_in;
    logic [WIDE_W-1:0]     wide_in;
    logic [WIDE_W-1:0]     wide_out;

    // occupancy count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_full;
    logic             is_empty;
    logic             has_two;

    // result of the item being taken
    logic                  accept;
    logic [WORD_WIDTH-1:0] res_word;
    deq_status_t           res_status;

    // two-entry result buffer
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    out_pop_reg;
    logic [VALUE_W-1:0]    out_pop_next;
    deq_status_t           out_status_reg;
    deq_status_t           out_status_next;
    logic [CNT_W-1:0]      out_occ_reg;
    logic [CNT_W-1:0]      out_occ_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic [VALUE_W-1:0]    skid_pop_reg;
    logic [VALUE_W-1:0]    skid_pop_next;
    deq_status_t           skid_status_reg;
    deq_status_t           skid_status_next;
    logic [CNT_W-1:0]      skid_occ_reg;
    logic [CNT_W-1:0]      skid_occ_next;
    logic                  out_take;
    logic [VALUE_W-1:0]    res_pop;

    assign accept   = item_valid & ~item_stall;
    assign out_take = out_valid_reg & ~result_stall;

    // resize the push word to the stored width
    assign wide_in = WIDE_W'(push_value);
    assign word_in = wide_in[WORD_WIDTH-1:0];

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign has_two  = (count_reg > CNT_W'(1));

    // Decode: qualified one-hot command plus the result of this transfer.
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        res_word   = '0;
        res_status = ST_DONE;
        if (accept)
        begin
            case (deq_op_t'(func))
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.push_front = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.push_back = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop_front = 1'b1;
                        res_word       = front_word;
                        count_next     = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop_back = 1'b1;
                        res_word      = back_word;
                        count_next    = count_reg - 1'b1;
                    end
                end
                OP_ROT_LEFT:
                begin
                    ctrl.rot_left = has_two;
                end
                OP_ROT_RIGHT:
                begin
                    ctrl.rot_right = has_two;
                end
                default:
                begin
                    // unused codes: no-op
                end
            endcase
        end
    end

    // Row edges: cell 0 sees the push word (or the back word on a rotate
    // right) as its left neighbour; the last cell sees an empty right side.
    assign front_word = cell_data[0];
    assign head_in    = ctrl.rot_right ? back_word : word_in;
    assign bcast      = ctrl.rot_left  ? front_word : word_in;

    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word = back_word | cell_tap[i];
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                  lv;
        logic [WORD_WIDTH-1:0] ld;
        logic                  rv;
        logic [WORD_WIDTH-1:0] rd;

        if (g == 0)
        begin : g_head
            assign lv = 1'b1;
            assign ld = head_in;
        end
        else
        begin : g_mid_l
            assign lv = valid_vec[g-1];
            assign ld = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rd = '0;
        end
        else
        begin : g_mid_r
            assign rv = valid_vec[g+1];
            assign rd = cell_data[g+1];
        end

        deq_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .bcast_data  (bcast),
            .valid       (valid_vec[g]),
            .data        (cell_data[g]),
            .tap         (cell_tap[g])
        );
    end

    // resize the popped word to the port width
    assign wide_out = WIDE_W'(res_word);
    assign res_pop  = wide_out[VALUE_W-1:0];

    // Result buffer: new result goes to the output entry when it is free or
    // being taken, otherwise to the skid entry, which moves up when the output is taken.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_pop_next     = out_pop_reg;
        out_status_next  = out_status_reg;
        out_occ_next     = out_occ_reg;
        skid_valid_next  = skid_valid_reg;
        skid_pop_next    = skid_pop_reg;
        skid_status_next = skid_status_reg;
        skid_occ_next    = skid_occ_reg;
        if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next  = 1'b1;
                out_pop_next    = res_pop;
                out_status_next = res_status;
                out_occ_next    = count_next;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_pop_next    = res_pop;
                skid_status_next = res_status;
                skid_occ_next    = count_next;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_pop_next    = skid_pop_reg;
                out_status_next = skid_status_reg;
                out_occ_next    = skid_occ_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pop_reg     <= out_pop_next;
        out_status_reg  <= out_status_next;
        out_occ_reg     <= out_occ_next;
        skid_pop_reg    <= skid_pop_next;
        skid_status_reg <= skid_status_next;
        skid_occ_reg    <= skid_occ_next;
    end

    assign item_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign pop_value    = out_pop_reg;
    assign status       = out_status_reg;
    assign occupancy    = out_occ_reg;

    // count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("count out of step with cell valid bits");

    // elements stay packed towards cell 0
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in the cell row");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with output entry empty");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full &&
         (func == OP_PUSH_FRONT || func == OP_PUSH_BACK)) |=> $stable(valid_vec))
        else $error("push on full queue changed the row");

    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_full &&
         (func == OP_PUSH_FRONT || func == OP_PUSH_BACK))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the queue");

endmodule : double_ended_queue

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for double_ended_queue: directed and random transfers
// against a behavioural deque predictor, with random stalls on both channels.
// Depends on deq_pkg (op and status codes, field widths) and the RTL top level.
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int DEPTH       = DEQ_DEPTH;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to wait after the last result for anything stray to appear.
    localparam int SETTLE_CYCLES = 20;
    // Receiver hold-off used to back the queue up into its input.
    localparam int LONG_HOLD = 80;

    // func codes the block does not define; both must act as no-ops.
    localparam logic [FUNC_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] OP_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        deq_status_t        st;
        logic [OCC_W-1:0]   occ;
    } deq_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic [FUNC_W-1:0]   func;
    logic [VALUE_W-1:0]  push_value;
    logic                result_valid;
    logic                result_stall;
    logic [VALUE_W-1:0]  pop_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    // Predictor state: ring of words, front slot, slot past the back, count.
    logic [DEQ_WORD_WIDTH-1:0] ring [DEPTH];
    logic [IDX_W-1:0]          head_slot;
    logic [IDX_W-1:0]          tail_slot;
    logic [OCC_W-1:0]          fill_level;

    deq_result_t pending_results[$];
    deq_result_t want;

    int errors;
    int cycle_count;
    int items_sent;
    int results_seen;
    int empty_pops;
    int full_pushes;
    int rotations_moved;
    int peak_fill;

    // Idling controls shared between the stimulus and the receiver process.
    bit source_idling;
    bit sink_idling;
    bit hold_request;

    double_ended_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .push_value   (push_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pop_value    (pop_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    always #5 clk = ~clk;

    // Timeout: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one operation to the predicted deque and returns the result it
    // should produce. Indices wrap on their own since DEPTH is a power of two.
    function automatic deq_result_t apply_deque_op(input logic [FUNC_W-1:0] op,
                                                   input logic [VALUE_W-1:0] word);
        deq_result_t r;
        r.word = '0;
        r.st   = ST_DONE;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (fill_level == DEPTH)
                begin
                    r.st = ST_FULL;
                    full_pushes++;
                end
                else
                begin
                    head_slot       = head_slot - 1'b1;
                    ring[head_slot] = word[DEQ_WORD_WIDTH-1:0];
                    fill_level++;
                end
            end
            OP_PUSH_BACK:
            begin
                if (fill_level == DEPTH)
                begin
                    r.st = ST_FULL;
                    full_pushes++;
                end
                else
                begin
                    ring[tail_slot] = word[DEQ_WORD_WIDTH-1:0];
                    tail_slot       = tail_slot + 1'b1;
                    fill_level++;
                end
            end
            OP_POP_FRONT:
            begin
                if (fill_level == 0)
                begin
                    r.st = ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    r.word    = VALUE_W'(ring[head_slot]);
                    head_slot = head_slot + 1'b1;
                    fill_level--;
                end
            end
            OP_POP_BACK:
            begin
                if (fill_level == 0)
                begin
                    r.st = ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    tail_slot = tail_slot - 1'b1;
                    r.word    = VALUE_W'(ring[tail_slot]);
                    fill_level--;
                end
            end
            // Rotations need two elements; on a full ring both ends move
            // together, so it is a true rotation.
            OP_ROT_LEFT:
            begin
                if (fill_level >= 2)
                begin
                    ring[tail_slot] = ring[head_slot];
                    head_slot       = head_slot + 1'b1;
                    tail_slot       = tail_slot + 1'b1;
                    rotations_moved++;
                end
            end
            OP_ROT_RIGHT:
            begin
                if (fill_level >= 2)
                begin
                    tail_slot       = tail_slot - 1'b1;
                    head_slot       = head_slot - 1'b1;
                    ring[head_slot] = ring[tail_slot];
                    rotations_moved++;
                end
            end
            default:
            begin
            end
        endcase
        r.occ = fill_level;
        if (fill_level > peak_fill)
            peak_fill = fill_level;
        return r;
    endfunction

    // Offers one item, with an occasional idle burst first, and holds it until
    // the transfer happens. Called at a rising edge; returns at the accepting
    // edge with valid still high, so back-to-back items need no extra NBA.
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] word);
        int gap;
        if (source_idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        func       <= op;
        push_value <= word;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(apply_deque_op(op, word));
        items_sent++;
    endtask

    // Drops valid and waits until every predicted result has been seen.
    task automatic wait_results_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    // Weighted op choice: push_pct / pop_pct percent, rotations fill most of
    // the rest, and a few unused codes as noise.
    function automatic logic [FUNC_W-1:0] pick_op(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        if (roll < 97)
            return $urandom_range(0, 1) ? OP_ROT_RIGHT : OP_ROT_LEFT;
        return $urandom_range(0, 1) ? OP_UNUSED_B : OP_UNUSED_A;
    endfunction

    // Empty queue corners: pops and rotates with nothing stored, unused
    // codes, then rotations with a single element, which must do nothing, and its pop.
    task automatic test_empty_queue();
        send_op(OP_POP_FRONT, '1);
        send_op(OP_POP_BACK, '1);
        send_op(OP_ROT_LEFT, '0);
        send_op(OP_ROT_RIGHT, '0);
        send_op(OP_UNUSED_A, '1);
        send_op(OP_UNUSED_B, '0);
        send_op(OP_PUSH_BACK, 32'h8000_0001);
        send_op(OP_ROT_LEFT, '1);
        send_op(OP_ROT_RIGHT, '1);
        send_op(OP_POP_FRONT, '0);
    endtask

    // Fill to the brim from both ends, starting with extreme words, push into the full
    // queue at either end, rotate it both ways, then take one off each end.
    task automatic test_full_queue();
        logic [VALUE_W-1:0] patterns [4];
        patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        for (int i = 0; i < DEPTH; i++)
            send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                    (i < 4) ? patterns[i] : pick_word());
        send_op(OP_PUSH_FRONT, 32'hDEAD_0000);
        send_op(OP_PUSH_BACK, 32'h0000_BEEF);
        send_op(OP_ROT_LEFT, '0);
        send_op(OP_ROT_RIGHT, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);
    endtask

    task automatic test_random_walk(input int count, input int push_pct, input int pop_pct);
        for (int i = 0; i < count; i++)
            send_op(pick_op(push_pct, pop_pct), pick_word());
    endtask

    // Receiver holds off for a long stretch while the sender offers without
    // gaps: the output buffer fills and the block must stall its input.
    task automatic test_output_hold();
        bit saved;
        saved         = source_idling;
        source_idling = 1'b0;
        hold_request  = 1'b1;
        test_random_walk(30, 50, 40);
        source_idling = saved;
        wait_results_drained();
    endtask

    // Sender stops mid-stream until every outstanding result has arrived.
    task automatic test_source_pause();
        test_random_walk(12, 45, 45);
        wait_results_drained();
        test_random_walk(12, 45, 45);
    endtask

    // Receiver side: random stall bursts, or one long hold when asked.
    initial
    begin
        int hold_left;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                hold_left = LONG_HOLD;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
                result_stall <= 1'b0;
            end
            else if (sink_idling && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Result checker: every transfer out is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result pop_value %h status %0d occupancy %0d",
                         $time, pop_value, status, occupancy);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (pop_value !== want.word)
                begin
                    $display("%0t: pop_value expected %h actual %h",
                             $time, want.word, pop_value);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    errors++;
                end
                if (occupancy !== want.occ)
                begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occ, occupancy);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        func          <= OP_PUSH_BACK;
        push_value    <= '0;
        head_slot     = '0;
        tail_slot     = '0;
        fill_level    = '0;
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        hold_request  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_full_queue();
        test_random_walk(500, 40, 40);
        test_output_hold();
        test_source_pause();
        test_random_walk(400, 60, 25);   // drifts towards full
        test_random_walk(400, 25, 60);   // drifts towards empty
        test_random_walk(300, 45, 45);

        // Closing stretch at full rate on both sides.
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        test_random_walk(300, 45, 45);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d transfers in, %0d out; %0d empty pops, %0d full pushes,",
                 items_sent, results_seen, empty_pops, full_pushes);
        $display("%0d moving rotations, peak occupancy %0d of %0d.",
                 rotations_moved, peak_fill, DEPTH);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue.sv
verif/tb.sv
